### rtl/mtep_pkg.sv
// Package for the track event parser: word types, event kind codes and
// byte constants. No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package mtep_pkg;

  // Field widths fixed by the word formats
  localparam int unsigned DATA_W      = 8;
  localparam int unsigned DELTA_OUT_W = 28;
  localparam int unsigned LEN_W       = 28;
  localparam int unsigned TEMPO_W     = 24;
  localparam int unsigned DELTA_BITS_DEF = 28;

  // Byte codes of the track format
  localparam logic [7:0] STATUS_FIRST = 8'h80;
  localparam logic [7:0] STATUS_LAST  = 8'hEF;
  localparam logic [7:0] SYSEX_START  = 8'hF0;
  localparam logic [7:0] SYSEX_ESCAPE = 8'hF7;
  localparam logic [7:0] META_PREFIX  = 8'hFF;
  localparam logic [7:0] META_EOT     = 8'h2F;
  localparam logic [7:0] META_TEMPO   = 8'h51;

  // High nibble of channel messages
  localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
  localparam logic [3:0] NIB_PROGRAM  = 4'hC;
  localparam logic [3:0] NIB_PRESSURE = 4'hD;

  typedef enum logic [2:0] {
    KIND_NOTE_OFF = 3'd0,
    KIND_NOTE_ON  = 3'd1,
    KIND_CHANNEL  = 3'd2,
    KIND_TEMPO    = 3'd3,
    KIND_END      = 3'd4,
    KIND_SKIPPED  = 3'd5
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       track_start;
  } in_word_t;

  typedef struct packed {
    kind_t       event_kind;
    logic [27:0] delta_ticks;
    logic [6:0]  note_key;
    logic [6:0]  note_velocity;
    logic [3:0]  channel;
    logic [23:0] tempo_us;
  } out_word_t;

  // Result handed from the parser core to the result register
  typedef struct packed {
    logic      valid;
    out_word_t word;
  } result_t;

endpackage

`default_nettype wire

### rtl/mtep_in_stage.sv
// Input register of the track event parser: holds one byte word until the
// parser core takes it. Depends on mtep_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtep_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mtep_pkg::in_word_t in_data,
  input  logic              slot_free,
  output logic              fire,
  output mtep_pkg::in_word_t word_q
);
  import mtep_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_word_t word_r;

  // Core consumes the held word whenever the result side has room
  assign fire     = valid_r && slot_free;
  assign in_stall = valid_r && !slot_free;
  assign word_q   = word_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && !in_stall) begin
      valid_nxt = 1'b1;
    end else if (fire) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture a new word on acceptance
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      word_r <= in_data;
    end
  end

endmodule

`default_nettype wire

### rtl/mtep_core.sv
// Parser core: delta decode, running status, meta and sysex skipping, and
// the per-track state registers. Depends on mtep_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtep_core #(
  parameter int unsigned DELTA_BITS = mtep_pkg::DELTA_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  mtep_pkg::in_word_t word_q,
  output mtep_pkg::result_t  result
);
  import mtep_pkg::*;

  typedef enum logic [6:0] {
    PH_DELTA  = 7'b0000001,
    PH_STATUS = 7'b0000010,
    PH_DATA1  = 7'b0000100,
    PH_DATA2  = 7'b0001000,
    PH_MTYPE  = 7'b0010000,
    PH_LEN    = 7'b0100000,
    PH_SKIP   = 7'b1000000
  } phase_t;

  phase_t                  phase_r, phase_nxt, phase_cur;
  logic [7:0]              rs_r, rs_nxt, rs_cur;
  logic [DELTA_BITS-1:0]   delta_r, delta_nxt, delta_cur;
  logic [6:0]              first_r, first_nxt, first_cur;
  logic [7:0]              meta_r, meta_nxt, meta_cur;
  logic [LEN_W-1:0]        left_r, left_nxt, left_cur;
  logic [TEMPO_W-1:0]      tempo_r, tempo_nxt, tempo_cur;
  logic                    seen_r, seen_nxt;
  logic                    ended_r, ended_nxt, ended_cur;
  logic [DELTA_BITS+DELTA_OUT_W-1:0] delta_wide;
  logic [7:0]              b;
  logic                    emit;
  logic                    data_in;
  logic                    chan_done;
  logic                    meta_done;
  logic [6:0]              second;
  out_word_t               res_word;

  assign b = word_q.data_byte;

  // Clear the track state first when the word opens a new track
  always_comb begin
    if (word_q.track_start) begin
      phase_cur = PH_DELTA;
      rs_cur    = '0;
      delta_cur = '0;
      first_cur = '0;
      meta_cur  = '0;
      left_cur  = '0;
      tempo_cur = '0;
      ended_cur = 1'b0;
    end else begin
      phase_cur = phase_r;
      rs_cur    = rs_r;
      delta_cur = delta_r;
      first_cur = first_r;
      meta_cur  = meta_r;
      left_cur  = left_r;
      tempo_cur = tempo_r;
      ended_cur = ended_r;
    end
  end

  assign delta_wide = {{DELTA_OUT_W{1'b0}}, delta_cur};

  // Decode one byte against the current phase
  always_comb begin
    phase_nxt = phase_cur;
    rs_nxt    = rs_cur;
    delta_nxt = delta_cur;
    first_nxt = first_cur;
    meta_nxt  = meta_cur;
    left_nxt  = left_cur;
    tempo_nxt = tempo_cur;
    seen_nxt  = seen_r;
    ended_nxt = ended_cur;
    emit      = 1'b0;
    data_in   = 1'b0;
    chan_done = 1'b0;
    meta_done = 1'b0;
    second    = '0;
    res_word  = '0;

    if (!ended_cur) begin
      case (phase_cur)
        PH_STATUS: begin
          if (!b[7]) begin
            if (rs_cur inside {[STATUS_FIRST:STATUS_LAST]}) begin
              data_in = 1'b1;
            end else begin
              phase_nxt = PH_DELTA;
              delta_nxt = '0;
            end
          end else if (b < SYSEX_START) begin
            rs_nxt    = b;
            phase_nxt = PH_DATA1;
          end else if (b == META_PREFIX) begin
            rs_nxt    = '0;
            phase_nxt = PH_MTYPE;
          end else if (b == SYSEX_START || b == SYSEX_ESCAPE) begin
            rs_nxt    = '0;
            meta_nxt  = '0;
            left_nxt  = '0;
            tempo_nxt = '0;
            phase_nxt = PH_LEN;
          end else begin
            // Undefined system status: drop and wait for a new delta
            phase_nxt = PH_DELTA;
            delta_nxt = '0;
          end
        end
        PH_DATA1: begin
          data_in = 1'b1;
        end
        PH_DATA2: begin
          chan_done = 1'b1;
          second    = b[6:0];
        end
        PH_MTYPE: begin
          meta_nxt  = b;
          left_nxt  = '0;
          tempo_nxt = '0;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          left_nxt = {left_cur[LEN_W-8:0], b[6:0]};
          if (!b[7]) begin
            if (left_nxt == '0) begin
              meta_done = 1'b1;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          tempo_nxt = {tempo_cur[TEMPO_W-9:0], b};
          left_nxt  = left_cur - LEN_W'(1);
          if (left_nxt == '0) begin
            meta_done = 1'b1;
          end
        end
        default: begin
          // Shift in one delta digit; continuation bit keeps the phase
          delta_nxt = {delta_cur[DELTA_BITS-8:0], b[6:0]};
          phase_nxt = b[7] ? PH_DELTA : PH_STATUS;
        end
      endcase

      // First data byte of a channel message
      if (data_in) begin
        first_nxt = b[6:0];
        if (rs_cur[7:4] inside {NIB_PROGRAM, NIB_PRESSURE}) begin
          chan_done = 1'b1;
        end else begin
          phase_nxt = PH_DATA2;
        end
      end

      // Channel message complete
      if (chan_done) begin
        emit             = 1'b1;
        res_word.channel = rs_cur[3:0];
        case (rs_cur[7:4])
          NIB_NOTE_OFF: begin
            res_word.event_kind    = KIND_NOTE_OFF;
            res_word.note_key      = first_nxt;
            res_word.note_velocity = second;
          end
          NIB_NOTE_ON: begin
            res_word.event_kind    = (second == '0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
            res_word.note_key      = first_nxt;
            res_word.note_velocity = second;
          end
          default: begin
            res_word.event_kind = KIND_CHANNEL;
          end
        endcase
      end

      // Meta or sysex payload fully skipped
      if (meta_done) begin
        emit = 1'b1;
        if (meta_cur == META_EOT) begin
          ended_nxt           = 1'b1;
          res_word.event_kind = KIND_END;
        end else if (meta_cur == META_TEMPO && !seen_r && tempo_nxt != '0) begin
          seen_nxt            = 1'b1;
          res_word.event_kind = KIND_TEMPO;
          res_word.tempo_us   = tempo_nxt;
        end else begin
          res_word.event_kind = KIND_SKIPPED;
        end
      end

      // Close the event: report its delta and start a new one
      if (emit) begin
        res_word.delta_ticks = delta_wide[DELTA_OUT_W-1:0];
        phase_nxt            = PH_DELTA;
        delta_nxt            = '0;
      end
    end
  end

  assign result.valid = fire && emit;
  assign result.word  = res_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DELTA;
      rs_r    <= '0;
      delta_r <= '0;
      first_r <= '0;
      meta_r  <= '0;
      left_r  <= '0;
      tempo_r <= '0;
      seen_r  <= 1'b0;
      ended_r <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      rs_r    <= rs_nxt;
      delta_r <= delta_nxt;
      first_r <= first_nxt;
      meta_r  <= meta_nxt;
      left_r  <= left_nxt;
      tempo_r <= tempo_nxt;
      seen_r  <= seen_nxt;
      ended_r <= ended_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/mtep_out_stage.sv
// Result register of the track event parser: holds one event word while
// the output is stalled. Depends on mtep_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtep_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  mtep_pkg::result_t   result,
  output logic                slot_free,
  output logic                out_valid,
  input  logic                out_stall,
  output mtep_pkg::out_word_t out_data
);
  import mtep_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  out_word_t word_r;

  // Room for a new word when empty or when the held word leaves now
  assign slot_free = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_data  = word_r;

  assign valid_nxt = result.valid || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load a fresh result; core only offers one when the slot is free
  always_ff @(posedge clk) begin
    if (result.valid) begin
      word_r <= result.word;
    end
  end

endmodule

`default_nettype wire

### rtl/midi_track_event_parser.sv
// Top level of the track event parser: input register, parser core and
// result register. Depends on mtep_pkg, mtep_in_stage, mtep_core, mtep_out_stage.
//
// Takes track chunk data one byte word per cycle while the output is not
// stalled and returns one event word for each completed event. A byte is held
// in the input register and decoded from there straight into the result
// register, so a new byte can be accepted every cycle while the output is
// not stalled. Bytes that finish no event produce no word. in_stall rises
// only when a byte is waiting and the result register is full and stalled.
// No clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none

module midi_track_event_parser #(
  parameter int unsigned DELTA_BITS = mtep_pkg::DELTA_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mtep_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mtep_pkg::out_word_t out_data
);
  import mtep_pkg::*;

  logic     slot_free;
  logic     fire;
  in_word_t word_q;
  result_t  result;

  mtep_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .slot_free (slot_free),
    .fire      (fire),
    .word_q    (word_q)
  );

  mtep_core #(
    .DELTA_BITS (DELTA_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .word_q (word_q),
    .result (result)
  );

  mtep_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .result    (result),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### rtl/mtep_checker.sv
// Port checker for the track event parser, bound to the top level.
// Depends on mtep_pkg and midi_track_event_parser.
`timescale 1ns / 1ps
`default_nettype none

module mtep_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input mtep_pkg::out_word_t out_data
);
  import mtep_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word dropped or changed");

  // Never stall input while the result side is free
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with result side free");

  // Note fields only on note events
  a_note_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_kind != KIND_NOTE_OFF
      && out_data.event_kind != KIND_NOTE_ON
      |-> out_data.note_key == '0 && out_data.note_velocity == '0)
    else $error("note fields set on a non-note event");

  // Tempo, end and skipped events: no channel, and tempo only on tempo events
  a_meta_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_kind == KIND_TEMPO || out_data.event_kind == KIND_END
      || out_data.event_kind == KIND_SKIPPED)
      |-> out_data.channel == '0
        && (out_data.event_kind == KIND_TEMPO || out_data.tempo_us == '0))
    else $error("channel or tempo field set on wrong event kind");

  // A reported tempo is never zero
  a_tempo_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_kind == KIND_TEMPO |-> out_data.tempo_us != '0)
    else $error("zero tempo reported as tempo event");

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
